/* hw/rtl/utf8_stream_decoder_core_macros.svh */
// Assertion macros for the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/utf8d_pkg.sv */
// Types, constants and helper functions for the UTF-8 stream decoder.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned ACC_W = 31;

  localparam logic [7:0] CONT_MASK = 8'b1100_0000;
  localparam logic [7:0] CONT_MARK = 8'b1000_0000;
  localparam logic [7:0] LEAD6_MASK = 8'b1111_1100;
  localparam logic [7:0] LEAD6_MARK = 8'b1111_1100;
  localparam logic [7:0] LEAD5_MARK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_MASK = 8'b1111_1000;
  localparam logic [7:0] LEAD4_MARK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
  localparam logic [7:0] LEAD3_MARK = 8'b1110_0000;
  localparam logic [7:0] FIRST_ILLEGAL = 8'hFE;
  localparam logic [5:0] PAYLOAD6 = 6'b11_1111;

  localparam logic signed [31:0] ERR_POINT = -32'sd1;

  typedef logic [2:0] seq_len_t;
  typedef logic [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic signed [31:0] code_point;
    seq_len_t           seq_length;
    logic               bad_sequence;
  } result_t;

  // Least value that needs a sequence of the given length.
  function automatic acc_t min_value(input seq_len_t len);
    acc_t v;
    v = '0;
    unique case (len)
      3'd2:    v = acc_t'(32'h0000_0080);
      3'd3:    v = acc_t'(32'h0000_0800);
      3'd4:    v = acc_t'(32'h0001_0000);
      3'd5:    v = acc_t'(32'h0020_0000);
      3'd6:    v = acc_t'(32'h0400_0000);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/utf8d_ifs.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
`default_nettype none

interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface utf8d_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] code_point;
  logic [2:0]         seq_length;
  logic               bad_sequence;

  modport source (output valid, output code_point, output seq_length,
                  output bad_sequence, input ready);
  modport sink   (input valid, input code_point, input seq_length,
                  input bad_sequence, output ready);
endinterface

`default_nettype wire

/* hw/rtl/utf8_stream_decoder_core.sv */
// UTF-8 stream decoder (original 1-to-6-byte form): byte channel in, code points out.
//
// Usage: bytes enter on byte_stream, one per transaction, with end_of_stream
// marking the last byte of a buffer. Each transaction that ends a sequence
// produces exactly one transaction on point_stream carrying the code point,
// the number of bytes consumed and a bad_sequence flag (code_point is -1 on
// any error). Bytes that only open or extend a sequence produce nothing.
// Throughput is one byte per cycle while the output stage has room; decoding
// is a single pass of shifts and compares from the sequence state registers
// into the result register. The result of a byte enters the output stage at
// the edge that accepts it. A two-entry output stage (main plus skid
// register) lets the decoder keep taking bytes while a result waits; ready on
// byte_stream drops only when both entries are full, so a stalled receiver
// back-pressures the input after at most one extra result. Synchronous
// active-high reset returns the decoder to the idle state between sequences
// and empties the output stage.
`default_nettype none

module utf8_stream_decoder_core (
  input  wire logic    clk,
  input  wire logic    rst,
  utf8d_byte_if.sink   byte_stream,
  utf8d_point_if.source point_stream
);
  import utf8d_pkg::*;

  `include "utf8_stream_decoder_core_macros.svh"

  // Sequence state.
  seq_len_t bytes_left, bytes_left_next;
  seq_len_t expected_length, expected_length_next;
  acc_t     accumulator, accumulator_next;
  logic     sequence_failed, sequence_failed_next;

  // Output stage.
  result_t  main_res, skid_res;
  logic     main_valid, skid_valid;

  logic     res_valid;
  result_t  res;
  logic     in_fire, out_fire;

  logic [7:0] b;
  logic       last;
  seq_len_t   left_dec;
  acc_t       acc_shift;
  logic       failed_upd;

  assign b    = byte_stream.data_byte;
  assign last = byte_stream.end_of_stream;

  assign byte_stream.ready = !skid_valid;
  assign in_fire  = byte_stream.valid && byte_stream.ready;
  assign out_fire = point_stream.valid && point_stream.ready;

  assign left_dec   = bytes_left - 3'd1;
  assign acc_shift  = {accumulator[ACC_W-7:0], b[5:0] & PAYLOAD6};
  assign failed_upd = sequence_failed || ((b & CONT_MASK) != CONT_MARK);

  // Single-pass decode of one byte against the current sequence state.
  always_comb begin
    bytes_left_next      = bytes_left;
    expected_length_next = expected_length;
    accumulator_next     = accumulator;
    sequence_failed_next = sequence_failed;
    res_valid            = 1'b0;
    res.code_point       = ERR_POINT;
    res.seq_length       = 3'd1;
    res.bad_sequence     = 1'b1;

    if (bytes_left == '0) begin
      if (!b[7]) begin
        res_valid        = 1'b1;
        res.code_point   = {24'd0, b};
        res.bad_sequence = 1'b0;
      end else if (((b & CONT_MASK) == CONT_MARK) || (b >= FIRST_ILLEGAL)) begin
        // Stray continuation byte or a byte never legal in UTF-8.
        res_valid = 1'b1;
      end else if (last) begin
        // Lead byte cut off by the end of the buffer; state stays idle.
        res_valid = 1'b1;
      end else begin
        sequence_failed_next = 1'b0;
        priority if ((b & LEAD6_MASK) == LEAD6_MARK) begin
          expected_length_next = 3'd6;
          accumulator_next     = acc_t'(b[0]);
        end else if ((b & LEAD6_MASK) == LEAD5_MARK) begin
          expected_length_next = 3'd5;
          accumulator_next     = acc_t'(b[1:0]);
        end else if ((b & LEAD4_MASK) == LEAD4_MARK) begin
          expected_length_next = 3'd4;
          accumulator_next     = acc_t'(b[2:0]);
        end else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
          expected_length_next = 3'd3;
          accumulator_next     = acc_t'(b[3:0]);
        end else begin
          expected_length_next = 3'd2;
          accumulator_next     = acc_t'(b[4:0]);
        end
        bytes_left_next = expected_length_next - 3'd1;
      end
    end else if (left_dec == '0) begin
      // Final byte of the sequence: check form and overlong encoding.
      res_valid      = 1'b1;
      res.seq_length = expected_length;
      if (!failed_upd && (acc_shift >= min_value(expected_length))) begin
        res.code_point   = {1'b0, acc_shift};
        res.bad_sequence = 1'b0;
      end
      bytes_left_next      = '0;
      expected_length_next = '0;
      accumulator_next     = '0;
      sequence_failed_next = 1'b0;
    end else if (last) begin
      // Truncated: report the bytes taken so far and return to idle.
      res_valid            = 1'b1;
      res.seq_length       = expected_length - left_dec;
      bytes_left_next      = '0;
      expected_length_next = '0;
      accumulator_next     = '0;
      sequence_failed_next = 1'b0;
    end else begin
      bytes_left_next      = left_dec;
      accumulator_next     = acc_shift;
      sequence_failed_next = failed_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left      <= '0;
      expected_length <= '0;
      accumulator     <= '0;
      sequence_failed <= 1'b0;
    end else if (in_fire) begin
      bytes_left      <= bytes_left_next;
      expected_length <= expected_length_next;
      accumulator     <= accumulator_next;
      sequence_failed <= sequence_failed_next;
    end
  end

  // Two-entry output stage: the skid entry always drains into main first.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !main_valid) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= in_fire && res_valid;
      end else begin
        main_valid <= in_fire && res_valid;
        skid_valid <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !main_valid) begin
      if (skid_valid) begin
        main_res <= skid_res;
        if (in_fire && res_valid) begin
          skid_res <= res;
        end
      end else if (in_fire && res_valid) begin
        main_res <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_res <= res;
    end
  end

  assign point_stream.valid        = main_valid;
  assign point_stream.code_point   = main_res.code_point;
  assign point_stream.seq_length   = main_res.seq_length;
  assign point_stream.bad_sequence = main_res.bad_sequence;

  // The skid entry is only ever filled behind a held main entry.
  `UTF8D_ASSERT_NOW(a_skid_behind_main, skid_valid, main_valid, "skid holds data, main empty")
  // A sequence never expects more continuation bytes than its length allows.
  `UTF8D_ASSERT_NOW(a_left_below_len, bytes_left != '0, bytes_left < expected_length,
                    "continuation count exceeds sequence length")
  // A result produced while the receiver stalls a full main entry lands in skid.
  `UTF8D_ASSERT_NEXT(a_result_kept, in_fire && res_valid && main_valid && !out_fire,
                     skid_valid, "result dropped under stall")

endmodule

`default_nettype wire
